// File: sv/dbpp_pkg.sv
// Shared types and codes for the dot-bracket pair parser.
`timescale 1ns / 1ps

package dbpp_pkg;

  localparam int POS_W   = 10;
  localparam int SYM_W   = 8;
  localparam int SPAN_W  = 4;
  localparam int KIND_W  = 2;
  localparam int ERR_W   = 3;
  localparam int CFG_A_W = 2;
  localparam int TDATA_W = 32;

  // Configuration register indexes
  localparam logic [CFG_A_W-1:0] CFG_OPEN     = 2'd0;
  localparam logic [CFG_A_W-1:0] CFG_CLOSE    = 2'd1;
  localparam logic [CFG_A_W-1:0] CFG_UNPAIRED = 2'd2;
  localparam logic [CFG_A_W-1:0] CFG_MIN_SPAN = 2'd3;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_UNPAIRED = 2'd0;
  localparam logic [KIND_W-1:0] KIND_OPEN     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLOSE    = 2'd2;

  // Error codes
  localparam logic [ERR_W-1:0] ERR_OK         = 3'd0;
  localparam logic [ERR_W-1:0] ERR_LOOP_SMALL = 3'd1;
  localparam logic [ERR_W-1:0] ERR_BAD_CLOSE  = 3'd2;
  localparam logic [ERR_W-1:0] ERR_BAD_SYMBOL = 3'd3;
  localparam logic [ERR_W-1:0] ERR_PENDING    = 3'd4;
  localparam logic [ERR_W-1:0] ERR_OVERFLOW   = 3'd5;
  localparam logic [ERR_W-1:0] ERR_ABORTED    = 3'd6;

  // Reset values of the configuration registers
  localparam logic [SYM_W-1:0]  RST_OPEN     = 8'd40;
  localparam logic [SYM_W-1:0]  RST_CLOSE    = 8'd41;
  localparam logic [SYM_W-1:0]  RST_UNPAIRED = 8'd46;
  localparam logic [SPAN_W-1:0] RST_MIN_SPAN = 4'd4;

  typedef struct packed {
    logic             eos;
    logic [ERR_W-1:0]  error;
    logic [KIND_W-1:0] kind;
    logic [POS_W-1:0]  partner;
    logic [POS_W-1:0]  position;
  } result_t;

endpackage

// File: sv/dot_bracket_pair_parser_top.sv
// Top level of the dot-bracket pair parser: stack tracking and result buffering.
`timescale 1ns / 1ps

// Dot-bracket pair parser.
// Input stream (s_*): one structure character per transfer. s_tdata holds the
// symbol, s_tuser marks the first character of a string, s_tlast the final one.
// Output stream (m_*): one result per input transfer, in order. m_tdata holds
// position, partner, kind and error; m_tlast echoes the final-character flag.
// Configuration: cfg_we writes cfg_data into register cfg_addr (0 open symbol,
// 1 close symbol, 2 unpaired symbol, 3 minimum pair span); write only when idle.
// Output: each result is registered in the output register, or in the skid register
// while a result waits. Throughput: one character per cycle while the skid register
// is empty. The top of the open stack lives in a register and the entry below it
// is prefetched from the stack memory every cycle, so back-to-back pops and pushes never stall.
// Stall: a two-entry output buffer (output register plus skid register) lets
// one more transfer in while a result waits; s_tready drops once both are full.
// Reset: rst clears the stack depth, position, aborted flag and output buffer
// and restores the configuration defaults. The stack memory is not cleared;
// only entries below the current depth are ever used, so no clearing pass runs.
module dot_bracket_pair_parser_top #(
  parameter int MAX_LENGTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  // Input stream
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [dbpp_pkg::SYM_W-1:0]    s_tdata,   // [7:0] symbol
  input  logic                          s_tuser,   // [0] first
  input  logic                          s_tlast,
  // Output stream
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [dbpp_pkg::TDATA_W-1:0]  m_tdata,   // [9:0] position, [19:10] partner,
                                                   // [21:20] kind, [24:22] error, rest 0
  output logic                          m_tlast,
  // Configuration write port
  input  logic                          cfg_we,
  input  logic [dbpp_pkg::CFG_A_W-1:0]  cfg_addr,
  input  logic [dbpp_pkg::SYM_W-1:0]    cfg_data
);
  import dbpp_pkg::*;

  localparam int DEPTH_W = $clog2(MAX_LENGTH + 1);
  localparam int ADDR_W  = $clog2(MAX_LENGTH);
  localparam logic [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(MAX_LENGTH);
  localparam logic [DEPTH_W-1:0] DEPTH_ONE = DEPTH_W'(1);
  localparam logic [DEPTH_W-1:0] DEPTH_TWO = DEPTH_W'(2);

  // Configuration registers
  logic [SYM_W-1:0]  open_sym;
  logic [SYM_W-1:0]  close_sym;
  logic [SYM_W-1:0]  unp_sym;
  logic [SPAN_W-1:0] min_span;

  // Parser state
  logic [DEPTH_W-1:0] depth;
  logic [DEPTH_W-1:0] depth_next;
  logic [POS_W-1:0]   char_pos;
  logic               aborted;
  logic [POS_W-1:0]   tos;          // top entry of the open stack
  logic [POS_W-1:0]   tos_next;

  // Stack memory holds entries 0 .. depth-2; tos holds entry depth-1
  logic [POS_W-1:0]   stack_mem [MAX_LENGTH];
  logic [POS_W-1:0]   rd_data;
  logic [POS_W-1:0]   byp_data;
  logic               byp;
  logic [POS_W-1:0]   nos;          // entry depth-2
  logic               mem_we;
  logic [ADDR_W-1:0]  wr_addr;
  logic [ADDR_W-1:0]  rd_addr;

  // Output buffer
  result_t out_res;
  result_t skid_res;
  logic    skid_valid;
  result_t res;

  logic               accept;
  logic               out_take;
  logic [DEPTH_W-1:0] depth_eff;
  logic [POS_W-1:0]   pos;
  logic               aborted_eff;
  logic [POS_W-1:0]   span;
  logic [DEPTH_W-1:0] depth_new;
  logic [POS_W-1:0]   tos_new;
  logic               push;
  logic [ERR_W-1:0]   err;
  logic [KIND_W-1:0]  kind;
  logic [POS_W-1:0]   partner;

  assign s_tready = !skid_valid;
  assign accept   = s_tvalid && s_tready;
  assign out_take = m_tvalid && m_tready;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      open_sym  <= RST_OPEN;
      close_sym <= RST_CLOSE;
      unp_sym   <= RST_UNPAIRED;
      min_span  <= RST_MIN_SPAN;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_OPEN:     open_sym  <= cfg_data;
        CFG_CLOSE:    close_sym <= cfg_data;
        CFG_UNPAIRED: unp_sym   <= cfg_data;
        CFG_MIN_SPAN: min_span  <= cfg_data[SPAN_W-1:0];
        default:      ;
      endcase
    end
  end

  // A first character starts from an empty stack at position zero
  assign depth_eff   = s_tuser ? '0 : depth;
  assign pos         = s_tuser ? '0 : char_pos;
  assign aborted_eff = s_tuser ? 1'b0 : aborted;
  assign nos         = byp ? byp_data : rd_data;
  assign span        = pos - tos;

  // Classify the character and update the stack
  always_comb begin
    err       = ERR_OK;
    kind      = KIND_UNPAIRED;
    partner   = '0;
    push      = 1'b0;
    depth_new = depth_eff;
    tos_new   = tos;
    priority if (aborted_eff) begin
      err = ERR_ABORTED;
    end else if (s_tdata == unp_sym) begin
      kind = KIND_UNPAIRED;
    end else if (s_tdata == open_sym) begin
      if (depth_eff >= DEPTH_MAX) begin
        err = ERR_OVERFLOW;
      end else begin
        push      = 1'b1;
        depth_new = depth_eff + DEPTH_ONE;
        tos_new   = pos;
        kind      = KIND_OPEN;
      end
    end else if (s_tdata == close_sym) begin
      if (depth_eff == '0) begin
        err = ERR_BAD_CLOSE;
      end else if (span < {{(POS_W-SPAN_W){1'b0}}, min_span}) begin
        err = ERR_LOOP_SMALL;
      end else begin
        depth_new = depth_eff - DEPTH_ONE;
        tos_new   = nos;
        kind      = KIND_CLOSE;
        partner   = tos;
      end
    end else begin
      err = ERR_BAD_SYMBOL;
    end
    // Opens still pending at the end keep kind and partner
    if (err == ERR_OK && s_tlast && depth_new != '0) begin
      err = ERR_PENDING;
    end
    res.eos      = s_tlast;
    res.error    = err;
    res.kind     = kind;
    res.partner  = partner;
    res.position = pos;
  end

  assign depth_next = accept ? depth_new : depth;
  assign tos_next   = accept ? tos_new : tos;

  // Push spills the old top into memory; the read always prefetches depth_next-2
  assign mem_we  = accept && push && (depth_eff != '0);
  assign wr_addr = ADDR_W'(depth_eff - DEPTH_ONE);
  assign rd_addr = ADDR_W'(depth_next - DEPTH_TWO);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      stack_mem[wr_addr] <= tos;
    end
    rd_data <= stack_mem[rd_addr];
  end

  // Forward the spilled entry when the prefetch hits the address being written
  always_ff @(posedge clk) begin
    byp_data <= tos;
    if (rst) begin
      byp <= 1'b0;
    end else begin
      byp <= mem_we && (wr_addr == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    tos <= tos_next;
    if (rst) begin
      depth    <= '0;
      char_pos <= '0;
      aborted  <= 1'b0;
    end else if (accept) begin
      depth    <= depth_next;
      char_pos <= pos + POS_W'(1);
      aborted  <= (err != ERR_OK);
    end
  end

  // Output register plus skid register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_take || !m_tvalid) begin
      if (skid_valid) begin
        out_res    <= skid_res;
        m_tvalid   <= 1'b1;
        skid_valid <= 1'b0;
      end else if (accept) begin
        out_res  <= res;
        m_tvalid <= 1'b1;
      end else begin
        m_tvalid <= 1'b0;
      end
    end else if (accept) begin
      // Hold the waiting result, park the new one
      skid_res   <= res;
      skid_valid <= 1'b1;
    end
  end

  assign m_tdata = {{(TDATA_W - POS_W - POS_W - KIND_W - ERR_W){1'b0}},
                    out_res.error, out_res.kind, out_res.partner, out_res.position};
  assign m_tlast = out_res.eos;

  // The skid register only fills behind a waiting result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_tvalid)
    else $error("skid entry without a held output result");

  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    depth <= DEPTH_MAX)
    else $error("open stack depth beyond its limit");

  // Any error aborts the rest of the string
  a_error_aborts: assert property (@(posedge clk) disable iff (rst)
    accept && err != ERR_OK |=> aborted)
    else $error("error did not set the aborted flag");

  // Only a final result with opens still pending may report a pair kind alongside an error
  a_kind_with_error: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_res.kind != KIND_UNPAIRED |->
      out_res.error == ERR_OK || out_res.error == ERR_PENDING)
    else $error("pair kind reported with an error");

endmodule
